@@ hdl/csc_pkg.sv @@
// Shared constants, types and helpers for the census stereo cost block.
`timescale 1ns / 1ps

package csc_pkg;

    // Image store and window geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int WINDOW     = 5;
    localparam int MAX_DISP   = 64;

    localparam int HALF      = WINDOW / 2;
    localparam int WSPAN     = 2 * HALF + 1;
    localparam int NPIX      = WSPAN * WSPAN;
    localparam int CODE_BITS = NPIX - 1;
    localparam int COST_W    = $clog2(CODE_BITS + 1);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WIN_W  = $clog2(WSPAN);
    localparam int K_W    = $clog2(NPIX + 1);

    // Field widths of the channels
    localparam int PIX_W      = 8;
    localparam int FCOL_W     = 9;
    localparam int FROW_W     = 9;
    localparam int DISP_W     = 6;
    localparam int MCOST_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int WCFG_W     = 10;
    localparam int HCFG_W     = 10;
    localparam int NDCFG_W    = 7;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Match direction
    localparam logic DIR_LEFT_REF  = 1'b0;
    localparam logic DIR_RIGHT_REF = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIR  = 2'd3;

    // Control from the sequencer to the census compare unit
    typedef struct packed {
        logic capture;   // latch centre pixel
        logic compare;   // compare centre against neighbor
        logic ref_mode;  // build reference code (else score against it)
        logic clear;     // clear cost accumulator
    } t_cu_ctrl;

    // Neighbor coordinate: (pos + tap - HALF) modulo size, size >= 1
    function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] pos,
                                                  input logic [WIN_W-1:0] tap,
                                                  input logic [POS_W:0]   size);
        logic signed [POS_W+2:0] v;
        logic signed [POS_W+2:0] sz;
        v  = $signed({3'b000, pos}) + $signed((POS_W+3)'(tap))
             - $signed((POS_W+3)'(HALF));
        sz = $signed({2'b00, size});
        for (int i = 0; i < HALF; i++) begin
            if (v < 0) v = v + sz;
        end
        for (int i = 0; i < HALF; i++) begin
            if (v >= sz) v = v - sz;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

@@ hdl/csc_ifs.sv @@
// Channel interfaces: pixel/query input, cost output, configuration writes.
`timescale 1ns / 1ps

interface csc_pix_if;
    import csc_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [PIX_W-1:0]  left_pixel;
    logic [PIX_W-1:0]  right_pixel;
    logic [FCOL_W-1:0] col;
    logic [FROW_W-1:0] row;
    modport source (output valid, cmd, left_pixel, right_pixel, col, row, input ready);
    modport sink   (input valid, cmd, left_pixel, right_pixel, col, row, output ready);
endinterface

interface csc_cost_if;
    import csc_pkg::*;
    logic               valid;
    logic               ready;
    logic [DISP_W-1:0]  disparity;
    logic [MCOST_W-1:0] match_cost;
    logic               last;
    modport source (output valid, disparity, match_cost, last, input ready);
    modport sink   (input valid, disparity, match_cost, last, output ready);
endinterface

interface csc_cfg_if;
    import csc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/csc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module csc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/csc_census.sv @@
// Shared census compare unit: builds the reference code and scores other codes.
`timescale 1ns / 1ps

module csc_census (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csc_pkg::t_cu_ctrl     i_ctrl,
    input  logic [csc_pkg::PIX_W-1:0]  i_pixel,
    output logic [csc_pkg::COST_W-1:0] o_cost
);
    import csc_pkg::*;

    logic [PIX_W-1:0]     r_centre;
    logic [CODE_BITS-1:0] r_code;
    logic [COST_W-1:0]    r_cost;
    logic                 gt_bit;

    // The one comparator of the block
    assign gt_bit = (r_centre > i_pixel);

    // Centre and code: reference bits shift in, then rotate during scoring
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_centre <= i_pixel;
        end
        if (i_ctrl.compare) begin
            if (i_ctrl.ref_mode) begin
                r_code <= {gt_bit, r_code[CODE_BITS-1:1]};
            end else begin
                r_code <= {r_code[0], r_code[CODE_BITS-1:1]};
            end
        end
    end

    // Mismatch counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost <= '0;
        end else if (i_ctrl.clear) begin
            r_cost <= '0;
        end else if (i_ctrl.compare && !i_ctrl.ref_mode) begin
            r_cost <= r_cost + COST_W'(gt_bit ^ r_code[0]);
        end
    end

    assign o_cost = r_cost;

    a_ctrl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_ctrl.capture, i_ctrl.compare, i_ctrl.clear}))
        else $error("census unit got conflicting controls");

    a_cost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cost <= COST_W'(CODE_BITS))
        else $error("census cost above code width");

endmodule

@@ hdl/census_hamming_stereo_cost.sv @@
// Census stereo cost block: image stores, window sequencer and result register.
// Load item: accepted while idle, no result.
// Query item: the reference code is built first, then for each disparity the window is
// scored when the column is inside the image and skipped when it is not; the block goes
// back to idle before it takes the next item, and it waits while
// o_cost stalls. Each store has one read port, so one window pixel is read per cycle.
// Reset clears the sequencer and sets the registers to 512, 512, 64, left reference;
// the image stores are not cleared and hold nothing valid until loaded.
`timescale 1ns / 1ps

module census_hamming_stereo_cost (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csc_pix_if.sink     i_pix,
    csc_cfg_if.sink     i_cfg,
    csc_cost_if.source  o_cost
);
    import csc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REF    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DISP   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam int SUM_W = ((COL_W > DISP_W) ? COL_W : DISP_W) + 1;

    // Configuration registers
    logic [WCFG_W-1:0]  r_cfg_w;
    logic [HCFG_W-1:0]  r_cfg_h;
    logic [NDCFG_W-1:0] r_cfg_nd;
    logic               r_cfg_dir;

    // Query context
    logic [2:0]         r_state, n_state;
    logic [COL_W:0]     r_w, n_w;
    logic [ROW_W:0]     r_h, n_h;
    logic [NDCFG_W-1:0] r_nd, n_nd;
    logic               r_dir, n_dir;
    logic [COL_W-1:0]   r_x, n_x;
    logic [ROW_W-1:0]   r_y, n_y;
    logic [COL_W-1:0]   r_cx, n_cx;
    logic [DISP_W-1:0]  r_d, n_d;
    logic               r_oob, n_oob;
    logic [K_W-1:0]     r_k, n_k;
    logic [WIN_W-1:0]   r_wx, n_wx;
    logic [WIN_W-1:0]   r_wy, n_wy;
    logic               r_pend_c0, n_pend_c0;
    logic               r_pend_skip, n_pend_skip;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic [DISP_W-1:0]  r_out_disp;
    logic [MCOST_W-1:0] r_out_cost;
    logic               r_out_last;
    logic               out_load;

    logic               pix_fire, out_fire, is_last, in_range;
    logic [COL_W:0]     w_eff, x_full;
    logic [ROW_W:0]     h_eff, y_full;
    logic [NDCFG_W-1:0] nd_eff;
    logic [COL_W-1:0]   x_clamped, qx;
    logic [ROW_W-1:0]   y_clamped, qy;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic               we;
    logic [PIX_W-1:0]   left_rdata, right_rdata, pix_rdata;
    logic [COST_W-1:0]  cu_cost;
    t_cu_ctrl           cu_ctrl;

    assign pix_fire = i_pix.valid && i_pix.ready;
    assign out_fire = r_out_valid && o_cost.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= WCFG_W'(512);
            r_cfg_h   <= HCFG_W'(512);
            r_cfg_nd  <= NDCFG_W'(64);
            r_cfg_dir <= DIR_LEFT_REF;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMG_WIDTH:  r_cfg_w   <= i_cfg.data[WCFG_W-1:0];
                CFG_IMG_HEIGHT: r_cfg_h   <= i_cfg.data[HCFG_W-1:0];
                CFG_MAX_DISP:   r_cfg_nd  <= i_cfg.data[NDCFG_W-1:0];
                CFG_MATCH_DIR:  r_cfg_dir <= i_cfg.data[0];
                default:        r_cfg_dir <= r_cfg_dir;
            endcase
        end
    end

    // Saturated sizes and clamped query position
    always_comb begin
        if (r_cfg_w == '0)                    w_eff = (COL_W+1)'(1);
        else if (r_cfg_w > WCFG_W'(MAX_WIDTH)) w_eff = (COL_W+1)'(MAX_WIDTH);
        else                                  w_eff = (COL_W+1)'(r_cfg_w);
        if (r_cfg_h == '0)                     h_eff = (ROW_W+1)'(1);
        else if (r_cfg_h > HCFG_W'(MAX_HEIGHT)) h_eff = (ROW_W+1)'(MAX_HEIGHT);
        else                                   h_eff = (ROW_W+1)'(r_cfg_h);
        if (r_cfg_nd == '0)                    nd_eff = NDCFG_W'(1);
        else if (r_cfg_nd > NDCFG_W'(MAX_DISP)) nd_eff = NDCFG_W'(MAX_DISP);
        else                                   nd_eff = r_cfg_nd;
        x_full = (COL_W+1)'(i_pix.col);
        y_full = (ROW_W+1)'(i_pix.row);
        x_clamped = (i_pix.col >= w_eff) ? COL_W'(w_eff - 1'b1) : x_full[COL_W-1:0];
        y_clamped = (i_pix.row >= h_eff) ? ROW_W'(h_eff - 1'b1) : y_full[ROW_W-1:0];
    end

    // Load path: both stores written at the same address
    assign we    = pix_fire && (i_pix.cmd == CMD_LOAD)
                   && (i_pix.col < MAX_WIDTH) && (i_pix.row < MAX_HEIGHT);
    assign waddr = ADDR_W'(ADDR_W'(i_pix.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(i_pix.col));

    // Window read address: centre first, then taps in raster order
    always_comb begin
        if (r_k == '0) begin
            qx = r_cx;
            qy = r_y;
        end else begin
            qx = COL_W'(wrap_pos(POS_W'(r_cx), r_wx, (POS_W+1)'(r_w)));
            qy = ROW_W'(wrap_pos(POS_W'(r_y), r_wy, (POS_W+1)'(r_h)));
        end
        raddr = ADDR_W'(ADDR_W'(qy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(qx));
    end

    csc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_pix.left_pixel),
        .i_raddr (raddr),
        .o_rdata (left_rdata)
    );

    csc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_pix.right_pixel),
        .i_raddr (raddr),
        .o_rdata (right_rdata)
    );

    // Reference image in S_REF, the other one while scoring
    assign pix_rdata = (r_dir ^ (r_state == S_DISP)) ? right_rdata : left_rdata;

    csc_census u_census (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cu_ctrl),
        .i_pixel (pix_rdata),
        .o_cost  (cu_cost)
    );

    // Column check for the current disparity
    always_comb begin
        if (r_dir == DIR_LEFT_REF) begin
            in_range = (SUM_W'(r_x) >= SUM_W'(r_d));
        end else begin
            in_range = ((SUM_W'(r_x) + SUM_W'(r_d)) < SUM_W'(r_w));
        end
        is_last = ((NDCFG_W'(r_d) + 1'b1) == r_nd);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_h         = r_h;
        n_nd        = r_nd;
        n_dir       = r_dir;
        n_x         = r_x;
        n_y         = r_y;
        n_cx        = r_cx;
        n_d         = r_d;
        n_oob       = r_oob;
        n_k         = r_k;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_pend_c0   = 1'b0;
        n_pend_skip = 1'b0;
        out_load    = 1'b0;
        cu_ctrl     = '0;
        cu_ctrl.ref_mode = (r_state == S_REF);

        unique case (r_state)
            S_IDLE: begin
                if (pix_fire && (i_pix.cmd == CMD_QUERY)) begin
                    n_w     = w_eff;
                    n_h     = h_eff;
                    n_nd    = nd_eff;
                    n_dir   = r_cfg_dir;
                    n_x     = x_clamped;
                    n_y     = y_clamped;
                    n_cx    = x_clamped;
                    n_d     = '0;
                    n_k     = '0;
                    n_wx    = '0;
                    n_wy    = '0;
                    n_state = S_REF;
                end
            end
            S_REF, S_DISP: begin
                // data of the previous read arrives now
                if (r_k != '0) begin
                    cu_ctrl.capture = r_pend_c0;
                    cu_ctrl.compare = !r_pend_c0 && !r_pend_skip;
                end
                // slot 0 reads the centre, slots 1..NPIX the taps, one more slot drains
                if (r_k < K_W'(NPIX + 1)) begin
                    n_k = r_k + 1'b1;
                    if (r_k == '0) begin
                        n_pend_c0 = 1'b1;
                    end else begin
                        n_pend_skip = (r_wx == WIN_W'(HALF)) && (r_wy == WIN_W'(HALF));
                        if (r_wx == WIN_W'(WSPAN - 1)) begin
                            n_wx = '0;
                            n_wy = (r_wy == WIN_W'(WSPAN - 1)) ? '0 : r_wy + 1'b1;
                        end else begin
                            n_wx = r_wx + 1'b1;
                        end
                    end
                end else begin
                    n_state = (r_state == S_REF) ? S_DSTART : S_EMIT;
                end
            end
            S_DSTART: begin
                cu_ctrl.clear = 1'b1;
                n_k  = '0;
                n_wx = '0;
                n_wy = '0;
                if (in_range) begin
                    n_oob   = 1'b0;
                    n_cx    = (r_dir == DIR_LEFT_REF) ? COL_W'(SUM_W'(r_x) - SUM_W'(r_d))
                                                      : COL_W'(SUM_W'(r_x) + SUM_W'(r_d));
                    n_state = S_DISP;
                end else begin
                    n_oob   = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || out_fire) begin
                    out_load = 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_d     = r_d + 1'b1;
                        n_state = S_DSTART;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load ? 1'b1 : (out_fire ? 1'b0 : r_out_valid);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_d         <= '0;
            r_nd        <= NDCFG_W'(1);
            r_pend_c0   <= 1'b0;
            r_pend_skip <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_wx        <= n_wx;
            r_wy        <= n_wy;
            r_d         <= n_d;
            r_nd        <= n_nd;
            r_pend_c0   <= n_pend_c0;
            r_pend_skip <= n_pend_skip;
            r_out_valid <= n_out_valid;
        end
    end

    // Query context and result payload
    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_h   <= n_h;
        r_dir <= n_dir;
        r_x   <= n_x;
        r_y   <= n_y;
        r_cx  <= n_cx;
        r_oob <= n_oob;
        if (out_load) begin
            r_out_disp <= r_d;
            r_out_cost <= r_oob ? MCOST_W'(CODE_BITS) : MCOST_W'(cu_cost);
            r_out_last <= is_last;
        end
    end

    assign o_cost.valid      = r_out_valid;
    assign o_cost.disparity  = r_out_disp;
    assign o_cost.match_cost = r_out_cost;
    assign o_cost.last       = r_out_last;

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REF || r_state == S_DISP) |-> (r_k <= K_W'(NPIX + 1)))
        else $error("window slot counter overran");

    a_window_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REF || r_state == S_DISP) && r_k == K_W'(NPIX + 1))
        |-> (r_wx == '0 && r_wy == '0))
        else $error("window taps not fully walked at end of read");

    a_disp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (NDCFG_W'(r_d) < r_nd))
        else $error("disparity beyond query range");

    a_scored_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> !r_oob)
        else $error("scoring a column outside the image");

endmodule
